// File: rtl/ertp_pkg.sv
package ertp_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int ANG_W   = 17;
    localparam int MAT_W   = 18;
    localparam int CFG_W   = (COORD_W > ANG_W) ? COORD_W : ANG_W;
    localparam int IDX_W   = 3;
    localparam int ATAN_W  = 26;

    localparam int ANG_FULL    = 46080;
    localparam int ANG_HALF    = 23040;
    localparam int ANG_QUARTER = 11520;
    localparam int ONE_Q16     = 65536;
    localparam int GAIN_Q30    = 652032874;

    localparam logic [IDX_W-1:0] REG_ROLL    = 3'd0;
    localparam logic [IDX_W-1:0] REG_PITCH   = 3'd1;
    localparam logic [IDX_W-1:0] REG_YAW     = 3'd2;
    localparam logic [IDX_W-1:0] REG_SHIFT_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHIFT_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHIFT_Z = 3'd5;

    // atan(2^-i) in degrees Q.16, padded with zeros
    localparam logic signed [ATAN_W-1:0] ATAN_DEG [32] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      final_point;
    } pt_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      saturated;
        logic                      final_out;
    } pt_out_t;

endpackage

// File: rtl/euler_rotate_translate_point_top.sv
// Rigid transform of 3-D points: out = R * p + t, with R = Rz * Ry * Rx.
// Input channel in_valid / in_stall / in_data carries one point per transfer,
// output channel out_valid / out_stall / out_data one transformed point.
// Coordinates are signed Q16.16; results saturate and set the saturated flag.
// The point path is a four-stage pipeline; while no rebuild runs and the
// receiver does not stall, one point per cycle is taken and delivered.
// Configuration uses cfg_we / cfg_index / cfg_data: roll, pitch, yaw (in
// 1/128 degree) and shift x, y, z. An angle write rebuilds the matrix with
// one shared CORDIC unit and one shared multiplier: per angle a load, a
// reduction into +-90 degrees and a CORDIC rotation, or exact values at
// multiples of 90 degrees, then the matrix products.
// in_stall is held high for the whole rebuild.
// Reset zeroes angles, shifts and valid bits and loads the identity matrix.
// When the receiver stalls, each stage holds its point and empty stages
// still fill, so up to four points are taken before in_stall rises.
module euler_rotate_translate_point_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  ertp_pkg::pt_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output ertp_pkg::pt_out_t           out_data,
    input  logic                        cfg_we,
    input  logic [ertp_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ertp_pkg::CFG_W-1:0]  cfg_data
);
    import ertp_pkg::*;

    localparam int SW = $clog2(CORDIC_STEPS + 1);
    localparam int HW = COORD_W - FRAC_W;
    localparam int PH = HW + MAT_W;
    localparam int PL = FRAC_W + 1 + MAT_W;
    localparam int WH = COORD_W + 3;
    localparam int WL = PL + 2;
    localparam int VW = COORD_W + 4;
    localparam int CW = 34;
    localparam int RW = 18;

    localparam logic signed [MAT_W-1:0] M_ONE  = MAT_W'(ONE_Q16);
    localparam logic signed [MAT_W-1:0] M_ZERO = '0;
    localparam logic signed [RW-1:0] A_FULL    = RW'(ANG_FULL);
    localparam logic signed [RW-1:0] A_HALF    = RW'(ANG_HALF);
    localparam logic signed [RW-1:0] A_QUARTER = RW'(ANG_QUARTER);
    localparam logic signed [VW-1:0] V_MAX = VW'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [VW-1:0] V_MIN = -V_MAX - VW'(1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_START  = 5'b00010,
        ST_REDUCE = 5'b00100,
        ST_CORDIC = 5'b01000,
        ST_BUILD  = 5'b10000
    } seq_state_t;

    function automatic logic signed [MAT_W-1:0] lim(input logic signed [55:0] r);
        if (r > 56'sd65536) lim = M_ONE;
        else if (r < -56'sd65536) lim = -M_ONE;
        else lim = r[MAT_W-1:0];
    endfunction

    function automatic logic signed [MAT_W-1:0] fin14(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + CW'(8192)) >>> 14;
        fin14 = lim(56'(r));
    endfunction

    function automatic logic signed [MAT_W-1:0] fin16(input logic signed [53:0] v);
        logic signed [53:0] r;
        r = (v + 54'sd32768) >>> 16;
        fin16 = lim(56'(r));
    endfunction

    function automatic logic signed [MAT_W-1:0] fin32(input logic signed [55:0] v);
        logic signed [55:0] r;
        r = (v + 56'sd2147483648) >>> 32;
        fin32 = lim(r);
    endfunction

    // configuration registers
    logic signed [ANG_W-1:0]   ang_reg [3];
    logic signed [COORD_W-1:0] sh_reg  [3];
    logic signed [MAT_W-1:0]   mat_reg [9];

    // rebuild sequencer
    seq_state_t              state_reg;
    logic [1:0]              ai_reg;
    logic [SW-1:0]           step_reg;
    logic [4:0]              mc_reg;
    logic                    pend_reg;
    logic                    neg_reg;
    logic signed [RW-1:0]    red_reg;
    logic signed [CW-1:0]    x_reg, y_reg;
    logic signed [ATAN_W-1:0] z_reg;
    logic signed [MAT_W-1:0] s_reg [3];
    logic signed [MAT_W-1:0] c_reg [3];
    logic signed [53:0]      p_reg;
    logic signed [55:0]      acc_reg;

    logic ang_wr;
    logic busy;
    assign ang_wr = cfg_we && (cfg_index == REG_ROLL || cfg_index == REG_PITCH
                               || cfg_index == REG_YAW);
    assign busy = (state_reg != ST_IDLE) || pend_reg || ang_wr;

    // angle fold
    logic signed [RW-1:0] m2, m3;
    logic                 fold_neg;
    always_comb
    begin
        m2 = (red_reg > A_HALF) ? red_reg - A_FULL : red_reg;
        fold_neg = 1'b0;
        m3 = m2;
        if (m2 > A_QUARTER)
        begin
            m3 = m2 - A_HALF;
            fold_neg = 1'b1;
        end
        else if (m2 < -A_QUARTER)
        begin
            m3 = m2 + A_HALF;
            fold_neg = 1'b1;
        end
    end

    // cordic step
    logic signed [CW-1:0]     xs, ys;
    logic signed [ATAN_W-1:0] at;
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign at = ATAN_DEG[5'(step_reg)];

    // shared multiplier for matrix build
    logic signed [35:0] op_a;
    logic signed [MAT_W-1:0] op_b;
    logic signed [53:0] prod;
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (mc_reg)
            5'd0:  begin op_a = 36'(c_reg[2]); op_b = c_reg[1]; end
            5'd1:  begin op_a = 36'(s_reg[2]); op_b = c_reg[1]; end
            5'd2:  begin op_a = 36'(c_reg[1]); op_b = s_reg[0]; end
            5'd3:  begin op_a = 36'(c_reg[1]); op_b = c_reg[0]; end
            5'd4:  begin op_a = 36'(c_reg[2]); op_b = s_reg[1]; end
            5'd5:  begin op_a = p_reg[35:0];   op_b = s_reg[0]; end
            5'd6:  begin op_a = 36'(s_reg[2]); op_b = c_reg[0]; end
            5'd7:  begin op_a = 36'(c_reg[2]); op_b = s_reg[1]; end
            5'd8:  begin op_a = p_reg[35:0];   op_b = c_reg[0]; end
            5'd9:  begin op_a = 36'(s_reg[2]); op_b = s_reg[0]; end
            5'd10: begin op_a = 36'(s_reg[2]); op_b = s_reg[1]; end
            5'd11: begin op_a = p_reg[35:0];   op_b = s_reg[0]; end
            5'd12: begin op_a = 36'(c_reg[2]); op_b = c_reg[0]; end
            5'd13: begin op_a = 36'(s_reg[2]); op_b = s_reg[1]; end
            5'd14: begin op_a = p_reg[35:0];   op_b = c_reg[0]; end
            5'd15: begin op_a = 36'(c_reg[2]); op_b = s_reg[0]; end
            default: ;
        endcase
    end
    assign prod = 54'(op_a) * 54'(op_b);

    logic signed [55:0] p_sh;
    assign p_sh = 56'(p_reg) <<< 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ai_reg    <= '0;
            step_reg  <= '0;
            mc_reg    <= '0;
            pend_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                ang_reg[i] <= '0;
                sh_reg[i]  <= '0;
            end
            for (int i = 0; i < 9; i++)
            begin
                mat_reg[i] <= (i == 0 || i == 4 || i == 8) ? M_ONE : M_ZERO;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ROLL:    ang_reg[0] <= cfg_data[ANG_W-1:0];
                    REG_PITCH:   ang_reg[1] <= cfg_data[ANG_W-1:0];
                    REG_YAW:     ang_reg[2] <= cfg_data[ANG_W-1:0];
                    REG_SHIFT_X: sh_reg[0]  <= cfg_data[COORD_W-1:0];
                    REG_SHIFT_Y: sh_reg[1]  <= cfg_data[COORD_W-1:0];
                    REG_SHIFT_Z: sh_reg[2]  <= cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end
            if (ang_wr && state_reg != ST_IDLE)
            begin
                pend_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (ang_wr || pend_reg)
                    begin
                        pend_reg  <= 1'b0;
                        ai_reg    <= '0;
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    red_reg   <= RW'(ang_reg[ai_reg]);
                    state_reg <= ST_REDUCE;
                end
                ST_REDUCE:
                begin
                    priority if (red_reg < 0)
                    begin
                        red_reg <= red_reg + A_FULL;
                    end
                    else if (red_reg >= A_FULL)
                    begin
                        red_reg <= red_reg - A_FULL;
                    end
                    else if (m3 == 0 || m3 == A_QUARTER || m3 == -A_QUARTER)
                    begin
                        // exact sine and cosine
                        priority if (m3 == 0)
                        begin
                            c_reg[ai_reg] <= fold_neg ? -M_ONE : M_ONE;
                            s_reg[ai_reg] <= M_ZERO;
                        end
                        else if (m3 == A_QUARTER)
                        begin
                            c_reg[ai_reg] <= M_ZERO;
                            s_reg[ai_reg] <= fold_neg ? -M_ONE : M_ONE;
                        end
                        else
                        begin
                            c_reg[ai_reg] <= M_ZERO;
                            s_reg[ai_reg] <= fold_neg ? M_ONE : -M_ONE;
                        end
                        if (ai_reg == 2'd2)
                        begin
                            mc_reg    <= '0;
                            state_reg <= ST_BUILD;
                        end
                        else
                        begin
                            ai_reg    <= ai_reg + 2'd1;
                            state_reg <= ST_START;
                        end
                    end
                    else
                    begin
                        neg_reg   <= fold_neg;
                        x_reg     <= CW'(GAIN_Q30);
                        y_reg     <= '0;
                        z_reg     <= ATAN_W'(m3) <<< 9;
                        step_reg  <= '0;
                        state_reg <= ST_CORDIC;
                    end
                end
                ST_CORDIC:
                begin
                    if (step_reg == SW'(CORDIC_STEPS))
                    begin
                        c_reg[ai_reg] <= neg_reg ? -fin14(x_reg) : fin14(x_reg);
                        s_reg[ai_reg] <= neg_reg ? -fin14(y_reg) : fin14(y_reg);
                        if (ai_reg == 2'd2)
                        begin
                            mc_reg    <= '0;
                            state_reg <= ST_BUILD;
                        end
                        else
                        begin
                            ai_reg    <= ai_reg + 2'd1;
                            state_reg <= ST_START;
                        end
                    end
                    else
                    begin
                        if (z_reg >= 0)
                        begin
                            x_reg <= x_reg - ys;
                            y_reg <= y_reg + xs;
                            z_reg <= z_reg - at;
                        end
                        else
                        begin
                            x_reg <= x_reg + ys;
                            y_reg <= y_reg - xs;
                            z_reg <= z_reg + at;
                        end
                        step_reg <= step_reg + SW'(1);
                    end
                end
                ST_BUILD:
                begin
                    p_reg  <= prod;
                    mc_reg <= mc_reg + 5'd1;
                    unique case (mc_reg)
                        5'd1:  mat_reg[0] <= fin16(p_reg);
                        5'd2:  mat_reg[3] <= fin16(p_reg);
                        5'd3:  mat_reg[7] <= fin16(p_reg);
                        5'd4:  mat_reg[8] <= fin16(p_reg);
                        5'd6, 5'd9, 5'd12, 5'd15: acc_reg <= 56'(p_reg);
                        5'd7:  mat_reg[1] <= fin32(acc_reg - p_sh);
                        5'd10: mat_reg[2] <= fin32(acc_reg + p_sh);
                        5'd13: mat_reg[4] <= fin32(acc_reg + p_sh);
                        5'd16:
                        begin
                            mat_reg[5] <= fin32(acc_reg - p_sh);
                            mat_reg[6] <= lim(56'(-s_reg[1]));
                            state_reg  <= ST_IDLE;
                        end
                        default: ;
                    endcase
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // point pipeline
    logic v1_reg, v2_reg, v3_reg, ov_reg;
    logic en1, en2, en3, en4;
    assign en4 = !ov_reg || !out_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = busy || !en1;

    logic signed [HW-1:0]     hi_reg [3];
    logic [FRAC_W-1:0]        lo_reg [3];
    logic                     f1_reg, f2_reg, f3_reg;
    logic signed [PH-1:0]     ph_reg [9];
    logic signed [PL-1:0]     pl_reg [9];
    logic signed [WH-1:0]     wh_reg [3];
    logic signed [WL-1:0]     wl_reg [3];
    pt_out_t                  out_reg;

    logic signed [COORD_W-1:0] pin [3];
    assign pin[0] = in_data.point_x;
    assign pin[1] = in_data.point_y;
    assign pin[2] = in_data.point_z;

    logic signed [COORD_W-1:0] res [3];
    logic [2:0]                clip;
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            logic signed [VW-1:0] v;
            v = VW'(wh_reg[r]) + VW'((wl_reg[r] + WL'(32768)) >>> 16);
            clip[r] = (v > V_MAX) || (v < V_MIN);
            if (v > V_MAX) res[r] = V_MAX[COORD_W-1:0];
            else if (v < V_MIN) res[r] = V_MIN[COORD_W-1:0];
            else res[r] = v[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid && !busy;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) ov_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int k = 0; k < 3; k++)
            begin
                hi_reg[k] <= pin[k][COORD_W-1:FRAC_W];
                lo_reg[k] <= pin[k][FRAC_W-1:0];
            end
            f1_reg <= in_data.final_point;
        end
        if (en2)
        begin
            for (int i = 0; i < 9; i++)
            begin
                ph_reg[i] <= PH'(hi_reg[i % 3]) * PH'(mat_reg[i]);
                pl_reg[i] <= PL'($signed({1'b0, lo_reg[i % 3]})) * PL'(mat_reg[i]);
            end
            f2_reg <= f1_reg;
        end
        if (en3)
        begin
            for (int r = 0; r < 3; r++)
            begin
                wh_reg[r] <= WH'(sh_reg[r]) + WH'(ph_reg[3*r]) + WH'(ph_reg[3*r+1])
                             + WH'(ph_reg[3*r+2]);
                wl_reg[r] <= WL'(pl_reg[3*r]) + WL'(pl_reg[3*r+1]) + WL'(pl_reg[3*r+2]);
            end
            f3_reg <= f2_reg;
        end
        if (en4)
        begin
            out_reg.out_x     <= res[0];
            out_reg.out_y     <= res[1];
            out_reg.out_z     <= res[2];
            out_reg.saturated <= |clip;
            out_reg.final_out <= f3_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_no_transfer_in_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (state_reg == ST_IDLE && !pend_reg))
        else $error("point taken during matrix rebuild");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORDIC) |-> (step_reg <= SW'(CORDIC_STEPS)))
        else $error("cordic step out of range");
    a_angle_index: assert property (@(posedge clk) disable iff (!rst_n)
        ai_reg != 2'd3)
        else $error("angle index out of range");
    a_build_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUILD && mc_reg == 5'd16) |=> (state_reg == ST_IDLE))
        else $error("matrix build did not finish");
`endif

endmodule
